// ===== rtl/srb_pkg.sv =====
// Package for the SYN rate block-list detector: beat structs, event codes, defaults.
// No dependencies.
package srb_pkg;

   localparam int TrackEntriesDefault = 16;
   localparam int RingDepthDefault    = 10;
   localparam int BlockEntriesDefault = 20;
   localparam int WindowWidth         = 20;
   localparam logic [WindowWidth-1:0] WindowReset = 20'd100;

   localparam logic [2:0] EV_NOT_SYN   = 3'd0;
   localparam logic [2:0] EV_TRACKED   = 3'd1;
   localparam logic [2:0] EV_UNTRACKED = 3'd2;
   localparam logic [2:0] EV_TBL_RESET = 3'd3;
   localparam logic [2:0] EV_BLOCKED   = 3'd4;
   localparam logic [2:0] EV_NEW_BLOCK = 3'd5;

   typedef struct packed {
      logic        eligible;
      logic        syn_bit;
      logic        ack_bit;
      logic [31:0] src_ip;
      logic [31:0] now_tick;
   } req_type;

   typedef struct packed {
      logic       drop;
      logic [2:0] event_res;
   } rsp_type;

   // front-to-back queue entry
   typedef struct packed {
      logic        is_syn;
      logic [31:0] src_ip;
      logic [31:0] now_tick;
   } work_type;

endpackage

// ===== rtl/srb_ram.sv =====
// Generic single-port write, single read port RAM with registered read.
// No dependencies.
module srb_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/srb_front.sv =====
// Front end: accepts request beats, classifies SYNs and pushes work into a 2-entry queue.
// Depends on srb_pkg.
module srb_front
   import srb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     wq_valid,
   input  logic     wq_ready,
   output work_type wq_data
);
   work_type q_ff [2];
   logic     rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic     push, pop;
   work_type item;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign wq_valid  = (cnt_ff != 2'd0);
   assign pop       = wq_valid && wq_ready;
   assign wq_data   = q_ff[rd_ptr_ff];

   always_comb begin
      item.is_syn   = req_data.eligible && req_data.syn_bit && !req_data.ack_bit;
      item.src_ip   = req_data.src_ip;
      item.now_tick = req_data.now_tick;
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) q_ff[wr_ptr_ff] <= item;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset) cnt_ff == 2'd2 |-> !req_ready)
      else $error("ready while queue full");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 && !push |=> cnt_ff == 2'd0)
      else $error("queue count grew without a push");
endmodule

// ===== rtl/srb_back.sv =====
// Back end: block-list and tracker lookup, ring update in a RAM, verdict register.
// Depends on srb_pkg and srb_ram.
module srb_back
   import srb_pkg::*;
#(
   parameter int TrackEntries = TrackEntriesDefault,
   parameter int RingDepth    = RingDepthDefault,
   parameter int BlockEntries = BlockEntriesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [WindowWidth-1:0] window,
   input  logic                   wq_valid,
   output logic                   wq_ready,
   input  work_type               wq_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data
);
   localparam int TW = (TrackEntries > 1) ? $clog2(TrackEntries) : 1;
   localparam int BW = (BlockEntries > 1) ? $clog2(BlockEntries) : 1;
   localparam int SW = $clog2(RingDepth);
   localparam int RamDepth = TrackEntries * RingDepth;
   localparam int AW = $clog2(RamDepth);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   work_type   cur_ff;

   logic [TrackEntries-1:0] trk_valid_ff, trk_full_ff;
   logic [31:0]   trk_ip_ff   [TrackEntries];
   logic [31:0]   trk_last_ff [TrackEntries];
   logic [SW-1:0] trk_slot_ff [TrackEntries];
   logic [BlockEntries-1:0] blk_valid_ff;
   logic [31:0]   blk_ip_ff   [BlockEntries];

   logic          blk_hit, any, recent, hit_found, free_found, blk_free_found;
   logic [TW-1:0] hit_idx, free_idx;
   logic [BW-1:0] blk_free_idx;
   logic          hit_ff;
   logic [TW-1:0] hit_idx_ff;
   logic [SW-1:0] new_slot_ff;
   logic          full_now_ff;

   logic          ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [31:0]   ram_rd;

   logic    out_full_ff;
   rsp_type out_ff, res;
   logic    res_en;

   // lookup over small tables
   always_comb begin
      blk_hit = 1'b0;
      blk_free_found = 1'b0;
      blk_free_idx = '0;
      for (int i = 0; i < BlockEntries; i++) begin
         if (blk_valid_ff[i] && blk_ip_ff[i] == cur_ff.src_ip) blk_hit = 1'b1;
         if (!blk_valid_ff[i] && !blk_free_found) begin
            blk_free_found = 1'b1;
            blk_free_idx = BW'(i);
         end
      end
      any = 1'b0; recent = 1'b0; hit_found = 1'b0; free_found = 1'b0;
      hit_idx = '0; free_idx = '0;
      for (int i = 0; i < TrackEntries; i++) begin
         if (trk_valid_ff[i]) begin
            any = 1'b1;
            if ((cur_ff.now_tick - trk_last_ff[i]) <= {12'd0, window}) recent = 1'b1;
            if (trk_ip_ff[i] == cur_ff.src_ip) begin
               hit_found = 1'b1;
               hit_idx = TW'(i);
            end
         end else if (!free_found) begin
            free_found = 1'b1;
            free_idx = TW'(i);
         end
      end
   end

   logic [SW-1:0] nxt_slot, old_slot;
   always_comb begin
      nxt_slot = (trk_slot_ff[hit_idx] == SW'(RingDepth-1)) ? '0 : trk_slot_ff[hit_idx] + 1'b1;
      old_slot = (new_slot_ff == SW'(RingDepth-1)) ? '0 : new_slot_ff + 1'b1;
      ram_ra   = AW'(hit_idx_ff) * AW'(RingDepth) + AW'(old_slot);
   end

   // hold new work while a verdict beat is still waiting
   assign wq_ready = (state_ff == ST_IDLE) && !out_full_ff;

   always_comb begin
      state_in = state_ff;
      res_en = 1'b0;
      res = '0;
      ram_we = 1'b0;
      ram_wa = '0;
      unique case (state_ff)
         ST_IDLE: if (wq_valid && wq_ready) state_in = ST_SCAN;
         ST_SCAN: begin
            if (!cur_ff.is_syn) begin
               res_en = 1'b1; res = '{1'b0, EV_NOT_SYN};
            end else if (blk_hit) begin
               res_en = 1'b1; res = '{1'b1, EV_BLOCKED};
            end else if (any && !recent) begin
               res_en = 1'b1; res = '{1'b0, EV_TBL_RESET};
            end else if (hit_found) begin
               ram_we = 1'b1;
               ram_wa = AW'(hit_idx) * AW'(RingDepth) + AW'(nxt_slot);
            end else if (!free_found) begin
               res_en = 1'b1; res = '{1'b0, EV_UNTRACKED};
            end else begin
               ram_we = 1'b1;
               ram_wa = AW'(free_idx) * AW'(RingDepth);
               res_en = 1'b1; res = '{1'b0, EV_TRACKED};
            end
            state_in = res_en ? ST_DONE : ST_READ;
         end
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (!out_full_ff) begin
               if (!hit_ff) state_in = ST_IDLE;
               else begin
                  res_en = 1'b1;
                  if (full_now_ff && (cur_ff.now_tick - ram_rd) <= {12'd0, window})
                     res = '{1'b1, EV_NEW_BLOCK};
                  else
                     res = '{1'b0, EV_TRACKED};
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   srb_ram #(.Width(32), .Depth(RamDepth)) u_ring (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(cur_ff.now_tick),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   assign rsp_valid = out_full_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         trk_valid_ff <= '0;
         blk_valid_ff <= '0;
         out_full_ff  <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid && rsp_ready) out_full_ff <= 1'b0;
         if (wq_valid && wq_ready) hit_ff <= 1'b0;
         if (state_ff == ST_SCAN) begin
            if (res_en && res.event_res == EV_TBL_RESET) trk_valid_ff <= '0;
            else if (cur_ff.is_syn && !blk_hit && hit_found) begin
               hit_ff <= 1'b1;
               trk_slot_ff[hit_idx] <= nxt_slot;
               trk_last_ff[hit_idx] <= cur_ff.now_tick;
               if (nxt_slot == SW'(RingDepth-1)) trk_full_ff[hit_idx] <= 1'b1;
            end else if (cur_ff.is_syn && !blk_hit && free_found) begin
               trk_valid_ff[free_idx] <= 1'b1;
               trk_full_ff[free_idx]  <= 1'b0;
               trk_ip_ff[free_idx]    <= cur_ff.src_ip;
               trk_slot_ff[free_idx]  <= '0;
               trk_last_ff[free_idx]  <= cur_ff.now_tick;
            end
         end
         if (state_ff == ST_DONE && hit_ff && res_en) begin
            hit_ff <= 1'b0;
            if (res.drop) begin
               trk_valid_ff[hit_idx_ff] <= 1'b0;
               if (blk_free_found) begin
                  blk_valid_ff[blk_free_idx] <= 1'b1;
               end
            end
         end
         if (res_en) out_full_ff <= 1'b1;
      end
      if (wq_valid && wq_ready) cur_ff <= wq_data;
      if (state_ff == ST_SCAN) begin
         hit_idx_ff  <= hit_idx;
         new_slot_ff <= nxt_slot;
         full_now_ff <= trk_full_ff[hit_idx] || (nxt_slot == SW'(RingDepth-1));
      end
      if (state_ff == ST_DONE && hit_ff && res_en && res.drop && blk_free_found)
         blk_ip_ff[blk_free_idx] <= cur_ff.src_ip;
      if (res_en) out_ff <= res;
   end

   assert property (@(posedge clock) disable iff (reset) res_en |-> !out_full_ff)
      else $error("verdict overwrites a pending beat");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_DONE)
      else $error("ring read not followed by verdict");
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_SCAN)
      else $error("ring written outside scan");
endmodule

// ===== rtl/syn_rate_blocklist_core.sv =====
// Channel  | dir | handshake           | payload
// req      | in  | req_valid/req_ready | req_data (req_type)
// rsp      | out | rsp_valid/rsp_ready | rsp_data (rsp_type)
// csr      | in  | csr_wr_en           | csr_wr_data (window_ticks)
// The back end takes one item at a time: latch, table scan, ring RAM read, verdict.
// Only a tracked hit needs the registered ring RAM read; the front queue holds two items.
// Reset is synchronous and clears all trackers and block entries at once.
// A stalled rsp beat holds the back end; the front keeps accepting until its queue fills.
// Depends on srb_pkg, srb_front, srb_back, srb_ram.
module syn_rate_blocklist_core
   import srb_pkg::*;
#(
   parameter int TrackEntries = TrackEntriesDefault,
   parameter int RingDepth    = RingDepthDefault,
   parameter int BlockEntries = BlockEntriesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [WindowWidth-1:0] csr_wr_data
);
   logic [WindowWidth-1:0] window_ff;
   logic     wq_valid, wq_ready;
   work_type wq_data;

   always_ff @(posedge clock) begin
      if (reset) window_ff <= WindowReset;
      else if (csr_wr_en) window_ff <= csr_wr_data;
   end

   srb_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .wq_valid(wq_valid), .wq_ready(wq_ready), .wq_data(wq_data)
   );

   srb_back #(
      .TrackEntries(TrackEntries), .RingDepth(RingDepth), .BlockEntries(BlockEntries)
   ) u_back (
      .clock(clock), .reset(reset), .window(window_ff), .wq_valid(wq_valid),
      .wq_ready(wq_ready), .wq_data(wq_data), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule

// ===== test/tb_syn_rate_blocklist_core.sv =====
// Self-checking bench for syn_rate_blocklist_core: directed rows, then SYN bursts and noise
// over several window settings. Each beat is checked against an in-bench verdict predictor.
// Depends on srb_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_syn_rate_blocklist_core;
   import srb_pkg::*;

   localparam int TRK  = TrackEntriesDefault;
   localparam int RING = RingDepthDefault;
   localparam int BLK  = BlockEntriesDefault;

   typedef struct packed {
      logic        eligible;
      logic        syn_bit;
      logic        ack_bit;
      logic [31:0] src_ip;
      logic [31:0] now_tick;
      logic        chk;
      logic        drop;
      logic [2:0]  event_res;
   } row_type;

   localparam int NROWS = 19;
   localparam row_type DIRECTED [NROWS] = '{
      '{1'b0, 1'b1, 1'b0, 32'h0A000001, 32'd1000, 1'b1, 1'b0, EV_NOT_SYN},
      '{1'b1, 1'b0, 1'b0, 32'h0A000001, 32'd1000, 1'b1, 1'b0, EV_NOT_SYN},
      '{1'b1, 1'b1, 1'b1, 32'h0A000001, 32'd1000, 1'b1, 1'b0, EV_NOT_SYN},
      '{1'b1, 1'b1, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, EV_NOT_SYN},
      '{1'b1, 1'b1, 1'b0, 32'h0A000001, 32'd1000, 1'b1, 1'b0, EV_TRACKED},
      '{1'b1, 1'b1, 1'b0, 32'h0A000001, 32'd1001, 1'b1, 1'b0, EV_TRACKED},
      '{1'b1, 1'b1, 1'b0, 32'h0A000001, 32'd1002, 1'b1, 1'b0, EV_TRACKED},
      '{1'b1, 1'b1, 1'b0, 32'h0A000001, 32'd1003, 1'b1, 1'b0, EV_TRACKED},
      '{1'b1, 1'b1, 1'b0, 32'h0A000001, 32'd1004, 1'b1, 1'b0, EV_TRACKED},
      '{1'b1, 1'b1, 1'b0, 32'h0A000001, 32'd1005, 1'b1, 1'b0, EV_TRACKED},
      '{1'b1, 1'b1, 1'b0, 32'h0A000001, 32'd1006, 1'b1, 1'b0, EV_TRACKED},
      '{1'b1, 1'b1, 1'b0, 32'h0A000001, 32'd1007, 1'b1, 1'b0, EV_TRACKED},
      '{1'b1, 1'b1, 1'b0, 32'h0A000001, 32'd1008, 1'b1, 1'b0, EV_TRACKED},
      '{1'b1, 1'b1, 1'b0, 32'h0A000001, 32'd1009, 1'b1, 1'b1, EV_NEW_BLOCK},
      '{1'b1, 1'b1, 1'b0, 32'h0A000001, 32'd1010, 1'b1, 1'b1, EV_BLOCKED},
      '{1'b1, 1'b1, 1'b0, 32'h0A000002, 32'd1010, 1'b1, 1'b0, EV_TRACKED},
      '{1'b1, 1'b1, 1'b0, 32'h0A000003, 32'd5000, 1'b1, 1'b0, EV_TBL_RESET},
      '{1'b1, 1'b1, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, EV_NOT_SYN},
      '{1'b1, 1'b1, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 1'b0, EV_NOT_SYN}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_wr_en;
   logic [WindowWidth-1:0] csr_wr_data;

   // predictor state
   logic [WindowWidth-1:0] win;
   bit                     trk_on [TRK];
   logic [31:0]            trk_addr [TRK];
   logic [31:0]            trk_ring [TRK][RING];
   int                     trk_pos [TRK];
   bit                     trk_wrapped [TRK];
   logic [31:0]            trk_seen [TRK];
   bit                     blk_on [BLK];
   logic [31:0]            blk_addr [BLK];

   rsp_type pending_verdicts[$];
   int      errors;
   int      n_items;
   int      ev_count [8];
   bit      idle_on;
   bit      hold_start;
   int      hold_cnt;

   syn_rate_blocklist_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type judge_packet(req_type r);
      rsp_type     o;
      int          hit;
      int          free_t;
      bit          any;
      bit          recent;
      int          s;
      bit          stored;
      logic [31:0] age;
      o.drop      = 1'b0;
      o.event_res = EV_NOT_SYN;
      hit    = -1;
      free_t = -1;
      any    = 0;
      recent = 0;
      if (!(r.eligible && r.syn_bit && !r.ack_bit)) return o;
      for (int i = 0; i < BLK; i++) begin
         if (blk_on[i] && blk_addr[i] == r.src_ip) begin
            o.drop      = 1'b1;
            o.event_res = EV_BLOCKED;
            return o;
         end
      end
      for (int i = 0; i < TRK; i++) begin
         if (trk_on[i]) begin
            any = 1;
            age = r.now_tick - trk_seen[i];
            if (age <= {12'd0, win}) recent = 1;
            if (trk_addr[i] == r.src_ip) hit = i;
         end else if (free_t < 0) begin
            free_t = i;
         end
      end
      if (any && !recent) begin
         for (int i = 0; i < TRK; i++) trk_on[i] = 0;
         o.event_res = EV_TBL_RESET;
         return o;
      end
      if (hit >= 0) begin
         s = (trk_pos[hit] + 1) % RING;
         trk_pos[hit]     = s;
         trk_seen[hit]    = r.now_tick;
         trk_ring[hit][s] = r.now_tick;
         if (s == RING - 1) trk_wrapped[hit] = 1;
         age = r.now_tick - trk_ring[hit][(s + 1) % RING];
         if (trk_wrapped[hit] && age <= {12'd0, win}) begin
            trk_on[hit] = 0;
            stored = 0;
            // take the first free block slot; skip if the list is full
            for (int i = 0; i < BLK; i++) begin
               if (!stored && !blk_on[i]) begin
                  blk_on[i]   = 1;
                  blk_addr[i] = r.src_ip;
                  stored      = 1;
               end
            end
            o.drop      = 1'b1;
            o.event_res = EV_NEW_BLOCK;
            return o;
         end
         o.event_res = EV_TRACKED;
         return o;
      end
      if (free_t < 0) begin
         o.event_res = EV_UNTRACKED;
         return o;
      end
      trk_on[free_t]      = 1;
      trk_addr[free_t]    = r.src_ip;
      trk_pos[free_t]     = 0;
      trk_wrapped[free_t] = 0;
      trk_seen[free_t]    = r.now_tick;
      trk_ring[free_t][0] = r.now_tick;
      o.event_res = EV_TRACKED;
      return o;
   endfunction

   // Offer one beat, hold it until accepted, then queue its verdict.
   task automatic send_packet(req_type r, output rsp_type verdict);
      while (idle_on && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      verdict = judge_packet(r);
      pending_verdicts.push_back(verdict);
      ev_count[verdict.event_res]++;
      n_items++;
   endtask

   task automatic drain_and_write(logic [WindowWidth-1:0] w);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      win = w;
      csr_wr_en <= 1'b0;
   endtask

   // response side: check beats, stall at random, honor hold-off requests
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected beat drop=%0d event=%0d", $time,
                     rsp_data.drop, rsp_data.event_res);
            errors++;
         end else begin
            if (rsp_data.drop !== pending_verdicts[0].drop) begin
               $display("%0t: drop expected %0d actual %0d", $time,
                        pending_verdicts[0].drop, rsp_data.drop);
               errors++;
            end
            if (rsp_data.event_res !== pending_verdicts[0].event_res) begin
               $display("%0t: event expected %0d actual %0d", $time,
                        pending_verdicts[0].event_res, rsp_data.event_res);
               errors++;
            end
            void'(pending_verdicts.pop_front());
         end
      end
      if (hold_start) begin
         hold_start = 0;
         hold_cnt   = 300;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_on && $urandom_range(99) < 26);
      end
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [WindowWidth-1:0] windows [5];
      logic [31:0]            pool [24];
      logic [31:0]            tick;
      logic [31:0]            step_max;
      req_type                r;
      rsp_type                verdict;
      int                     kind;
      int                     sent;
      int                     burst;
      clock       = 0;
      reset       = 1;
      req_valid   = 0;
      req_data    = '0;
      rsp_ready   = 0;
      csr_wr_en   = 0;
      csr_wr_data = '0;
      errors      = 0;
      n_items     = 0;
      idle_on     = 1;
      hold_start  = 0;
      hold_cnt    = 0;
      win         = WindowReset;
      foreach (ev_count[i]) ev_count[i] = 0;
      foreach (trk_on[i]) trk_on[i] = 0;
      foreach (blk_on[i]) blk_on[i] = 0;
      windows = '{20'hFFFFF, 20'd1, 20'd0, 20'd1000000, 20'd100};
      foreach (pool[i]) pool[i] = $urandom;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NROWS; i++) begin
         r = '{DIRECTED[i].eligible, DIRECTED[i].syn_bit, DIRECTED[i].ack_bit,
               DIRECTED[i].src_ip, DIRECTED[i].now_tick};
         send_packet(r, verdict);
         if (DIRECTED[i].chk && (verdict.drop !== DIRECTED[i].drop ||
                                 verdict.event_res !== DIRECTED[i].event_res)) begin
            $display("%0t: row %0d expected %0d/%0d actual %0d/%0d", $time, i,
                     DIRECTED[i].drop, DIRECTED[i].event_res, verdict.drop,
                     verdict.event_res);
            errors++;
         end
      end

      for (int ph = 0; ph < 5; ph++) begin
         drain_and_write(windows[ph]);
         idle_on  = (ph != 2);
         tick     = $urandom;
         step_max = (win == 0) ? 32'd0 : {12'd0, win} / 8;
         sent     = 0;
         while (sent < 80) begin
            if (ph == 1 && sent >= 20 && hold_cnt == 0 && !hold_start && sent < 24)
               hold_start = 1;
            kind = $urandom_range(99);
            if (kind < 45) begin
               // burst from one pooled source, mostly inside the window
               burst = $urandom_range(8, 12);
               r.src_ip = pool[$urandom_range(23)];
               for (int b = 0; b < burst; b++) begin
                  tick += $urandom_range(step_max);
                  r.eligible = 1; r.syn_bit = 1; r.ack_bit = 0; r.now_tick = tick;
                  send_packet(r, verdict);
                  sent++;
               end
            end else if (kind < 65) begin
               tick += $urandom_range(step_max);
               r = '{1'b1, 1'b1, 1'b0, $urandom, tick};
               send_packet(r, verdict);
               sent++;
            end else if (kind < 80) begin
               r = '{$urandom_range(1), $urandom_range(1), $urandom_range(1),
                     $urandom, $urandom};
               send_packet(r, verdict);
               sent++;
            end else if (kind < 90) begin
               // jump past the window so every tracker goes stale
               tick += {12'd0, win} + 1 + $urandom_range(1000);
               r = '{1'b1, 1'b1, 1'b0, pool[$urandom_range(23)], tick};
               send_packet(r, verdict);
               sent++;
            end else begin
               tick += $urandom_range(4 * step_max + 1);
               r = '{1'b1, 1'b1, 1'b0, pool[$urandom_range(23)], tick};
               send_packet(r, verdict);
               sent++;
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Covered %0d packets over the reset window and 5 written ones: %0d tracked,",
               n_items, ev_count[EV_TRACKED]);
      $display("  %0d untracked, %0d table resets, %0d newly blocked, %0d already blocked, %0d non-SYN.",
               ev_count[EV_UNTRACKED], ev_count[EV_TBL_RESET], ev_count[EV_NEW_BLOCK],
               ev_count[EV_BLOCKED], ev_count[EV_NOT_SYN]);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/srb_pkg.sv
rtl/srb_ram.sv
rtl/srb_front.sv
rtl/srb_back.sv
rtl/syn_rate_blocklist_core.sv
test/tb_syn_rate_blocklist_core.sv
